@@ rtl/core/ccde_pkg.sv @@
// Shared types and constants for the control character display expander.
// No dependencies.
`timescale 1ns / 1ps

package ccde_pkg;

    localparam int CHAR_W      = 8;
    localparam int COL_W       = 17;
    localparam int MAX_RESULTS = 10;

    localparam logic [COL_W-1:0] COL_MAX     = 17'h1FFFF;
    localparam logic [COL_W-1:0] LIMIT_RESET = 17'h10000;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [CHAR_W-1:0] CH_BSL   = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_QMARK = 8'h3F;
    localparam logic [CHAR_W-1:0] CTRL_OR  = 8'h40;

    typedef enum logic [2:0] {
        CLS_PRINT,
        CLS_TAB,
        CLS_CR,
        CLS_LF,
        CLS_OCT,
        CLS_CARET
    } t_cls;

endpackage

@@ rtl/core/ccde_in_if.sv @@
// Input channel of the display expander: one raw terminal byte per beat.
// Depends on ccde_pkg.
`timescale 1ns / 1ps

interface ccde_in_if import ccde_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ch;
    logic              first_of_write;

    modport source (output valid, output ch, output first_of_write, input ready);
    modport sink   (input valid, input ch, input first_of_write, output ready);
endinterface

@@ rtl/core/ccde_out_if.sv @@
// Output channel of the display expander: one display byte per beat.
// Depends on ccde_pkg.
`timescale 1ns / 1ps

interface ccde_out_if import ccde_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

@@ rtl/core/control_char_display_expander.sv @@
// Top level of the control character display expander (caret and octal notation).
// Depends on ccde_pkg, ccde_in_if and ccde_out_if.
//
// Usage:
//   i_in  : raw terminal bytes, valid/ready, with first_of_write marking the
//           first byte of a write call.
//   o_out : display bytes, valid/ready, last set on the final byte of an input.
//   i_cfg_we / i_cfg_wdata : writes line_limit; write only while idle.
// The first display byte of an input is registered in the expansion stage and
// then in the output register before it shows on o_out.
// Throughput: one display byte per cycle while o_out.ready is high. An input
// yields as many display bytes as its class gives (1 to 10; printable 1, caret
// 2, octal 4, a tab up to TAB_STOP, plus 2 for a forced line break). The next
// input is taken in the cycle the last byte of the current one moves to the
// output register.
// Reset: column 0, line_limit 65536, no beats pending.
// Stall: when o_out.ready is low the output byte holds, the expansion stage
// waits, and i_in.ready drops once the stage holds an unfinished input.
`timescale 1ns / 1ps

module control_char_display_expander import ccde_pkg::*; #(
    parameter int TAB_STOP = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ccde_in_if.sink          i_in,
    ccde_out_if.source       o_out,
    input  logic             i_cfg_we,
    input  logic [COL_W-1:0] i_cfg_wdata
);

    localparam int POS_W  = $clog2(TAB_STOP);
    localparam int DIST_W = $clog2(TAB_STOP + 1);
    localparam int CNT_W  = $clog2(((TAB_STOP > MAX_RESULTS) ? TAB_STOP : MAX_RESULTS) + 3);
    localparam int IDX_W  = $clog2(MAX_RESULTS);

    localparam logic [POS_W-1:0] POS_SAT = POS_W'(int'(COL_MAX) % TAB_STOP);
    localparam logic [POS_W:0]   MOD1    = (POS_W+1)'(1 % TAB_STOP);
    localparam logic [POS_W:0]   MOD2    = (POS_W+1)'(2 % TAB_STOP);
    localparam logic [POS_W:0]   MOD4    = (POS_W+1)'(4 % TAB_STOP);
    localparam logic [POS_W:0]   TS_P    = (POS_W+1)'(TAB_STOP);

    // state
    logic [COL_W-1:0] r_limit;
    logic [COL_W-1:0] r_column, n_column;
    logic [POS_W-1:0] r_pos, n_pos;     // column mod TAB_STOP

    // expansion stage
    logic             r_d_valid;
    logic             r_d_brk, n_d_brk;
    t_cls             r_d_cls, n_d_cls;
    logic [CHAR_W-1:0] r_d_ch;
    logic [IDX_W-1:0] r_d_lastidx, n_d_lastidx;
    logic [IDX_W-1:0] r_d_idx;

    // output register
    logic              r_o_valid;
    logic [CHAR_W-1:0] r_o_char;
    logic              r_o_last;

    logic in_acc, load, d_done;

    // ---------------- decode of an accepted beat ----------------
    logic [COL_W-1:0]  col0;
    logic [POS_W-1:0]  pos0;
    logic [DIST_W-1:0] tab_gap;
    logic [CNT_W-1:0]  own_cnt, tot_cnt, cap_cnt;
    logic [COL_W:0]    col_sum;
    logic [COL_W:0]    adv;
    logic [POS_W:0]    pos_sum, pos_by;

    always_comb begin
        n_d_brk = i_in.first_of_write && (r_column > r_limit);
        col0    = n_d_brk ? '0 : r_column;
        pos0    = n_d_brk ? '0 : r_pos;
        tab_gap = DIST_W'(TAB_STOP) - DIST_W'(pos0);

        if (i_in.ch >= CH_SPACE && i_in.ch <= CH_TILDE) begin
            n_d_cls = CLS_PRINT;
        end else if (i_in.ch == CH_TAB) begin
            n_d_cls = CLS_TAB;
        end else if (i_in.ch == CH_CR) begin
            n_d_cls = CLS_CR;
        end else if (i_in.ch == CH_LF) begin
            n_d_cls = CLS_LF;
        end else if (i_in.ch[7]) begin
            n_d_cls = CLS_OCT;
        end else begin
            n_d_cls = CLS_CARET;
        end

        own_cnt = CNT_W'(1);
        adv     = (COL_W+1)'(1);
        pos_by  = MOD1;
        case (n_d_cls)
            CLS_PRINT: begin
                own_cnt = CNT_W'(1);
                adv     = (COL_W+1)'(1);
                pos_by  = MOD1;
            end
            CLS_TAB: begin
                own_cnt = CNT_W'(tab_gap);
                adv     = (COL_W+1)'(tab_gap);
                pos_by  = '0;
            end
            CLS_CR:    own_cnt = CNT_W'(1);
            CLS_LF:    own_cnt = CNT_W'(2);
            CLS_OCT: begin
                own_cnt = CNT_W'(4);
                adv     = (COL_W+1)'(4);
                pos_by  = MOD4;
            end
            default: begin
                own_cnt = CNT_W'(2);
                adv     = (COL_W+1)'(2);
                pos_by  = MOD2;
            end
        endcase

        tot_cnt = own_cnt + (n_d_brk ? CNT_W'(2) : CNT_W'(0));
        cap_cnt = (tot_cnt > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : tot_cnt;
        n_d_lastidx = IDX_W'(cap_cnt - CNT_W'(1));

        // column update; tab lands on a stop, so its mod is zero
        col_sum = {1'b0, col0} + adv;
        pos_sum = {1'b0, pos0} + pos_by;
        if (pos_sum >= TS_P) begin
            pos_sum = pos_sum - TS_P;
        end
        if (n_d_cls == CLS_CR || n_d_cls == CLS_LF) begin
            n_column = '0;
            n_pos    = '0;
        end else if (col_sum > {1'b0, COL_MAX}) begin
            n_column = COL_MAX;
            n_pos    = POS_SAT;
        end else begin
            n_column = col_sum[COL_W-1:0];
            n_pos    = (n_d_cls == CLS_TAB) ? '0 : pos_sum[POS_W-1:0];
        end
    end

    // ---------------- byte selection in the expansion stage ----------------
    logic [IDX_W-1:0]  j;
    logic [CHAR_W-1:0] sel_char;

    always_comb begin
        j        = r_d_idx - (r_d_brk ? IDX_W'(2) : IDX_W'(0));
        sel_char = CH_CR;
        if (r_d_brk && r_d_idx == IDX_W'(0)) begin
            sel_char = CH_CR;
        end else if (r_d_brk && r_d_idx == IDX_W'(1)) begin
            sel_char = CH_LF;
        end else begin
            case (r_d_cls)
                CLS_PRINT: sel_char = r_d_ch;
                CLS_TAB:   sel_char = CH_SPACE;
                CLS_CR:    sel_char = CH_CR;
                CLS_LF:    sel_char = (j == IDX_W'(0)) ? CH_CR : CH_LF;
                CLS_OCT: begin
                    case (j)
                        IDX_W'(0): sel_char = CH_BSL;
                        IDX_W'(1): sel_char = {6'b001100, r_d_ch[7:6]};
                        IDX_W'(2): sel_char = {5'b00110, r_d_ch[5:3]};
                        default:   sel_char = {5'b00110, r_d_ch[2:0]};
                    endcase
                end
                default: begin
                    if (j == IDX_W'(0)) begin
                        sel_char = CH_CARET;
                    end else if (r_d_ch == CH_DEL) begin
                        sel_char = CH_QMARK;
                    end else begin
                        sel_char = r_d_ch | CTRL_OR;
                    end
                end
            endcase
        end
    end

    // ---------------- handshakes ----------------
    assign load       = r_d_valid && (!r_o_valid || o_out.ready);
    assign d_done     = load && (r_d_idx == r_d_lastidx);
    assign i_in.ready = !r_d_valid || d_done;
    assign in_acc     = i_in.valid && i_in.ready;

    assign o_out.valid    = r_o_valid;
    assign o_out.out_char = r_o_char;
    assign o_out.last     = r_o_last;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_RESET;
            r_column  <= '0;
            r_pos     <= '0;
            r_d_valid <= 1'b0;
            r_d_idx   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end

            if (in_acc) begin
                r_column  <= n_column;
                r_pos     <= n_pos;
                r_d_valid <= 1'b1;
                r_d_idx   <= '0;
            end else if (d_done) begin
                r_d_valid <= 1'b0;
            end else if (load) begin
                r_d_idx <= r_d_idx + IDX_W'(1);
            end

            if (load) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_d_brk     <= n_d_brk;
            r_d_cls     <= n_d_cls;
            r_d_ch      <= i_in.ch;
            r_d_lastidx <= n_d_lastidx;
        end
        if (load) begin
            r_o_char <= sel_char;
            r_o_last <= (r_d_idx == r_d_lastidx);
        end
    end

endmodule
